### sv/lcdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LCD mode and line timing block.
// No dependencies; imported by lcdt_timing and lcd_mode_line_timing.
package lcdt_pkg;

  // Display modes, coded as the status register reports them
  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  // Field widths
  localparam int CYCLES_W   = 6;
  localparam int LINE_W     = 8;
  localparam int ACCUM_W    = 11;
  localparam int STAT_EN_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAT_INT_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE    = 1'b1;

  // Status interrupt enable bits
  localparam int STAT_EN_HBLANK = 0;
  localparam int STAT_EN_VBLANK = 1;
  localparam int STAT_EN_SEARCH = 2;
  localparam int STAT_EN_MATCH  = 3;

  // Configuration write bundle
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic              frame_done;
    logic              transfer_done;
    logic              search_done;
    logic              vblank_irq;
    logic              stat_irq;
    logic              line_match;
    logic [LINE_W-1:0] line;
    mode_t             mode;
  } result_t;

endpackage

### sv/lcdt_timing.sv
`timescale 1ns / 1ps
// Mode state machine, line counter, cycle accumulator and config registers.
// Depends on lcdt_pkg.
module lcdt_timing #(
  parameter int SEARCH_CYCLES   = 80,
  parameter int TRANSFER_CYCLES = 172,
  parameter int HBLANK_CYCLES   = 204,
  parameter int LINE_CYCLES     = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int BLANK_LINES     = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  logic [lcdt_pkg::CYCLES_W-1:0]   cycles,
  input  lcdt_pkg::cfg_wr_t               cfg,
  output lcdt_pkg::result_t               result
);
  import lcdt_pkg::*;

  localparam logic [ACCUM_W-1:0] SEARCH_C   = ACCUM_W'(SEARCH_CYCLES);
  localparam logic [ACCUM_W-1:0] TRANSFER_C = ACCUM_W'(TRANSFER_CYCLES);
  localparam logic [ACCUM_W-1:0] HBLANK_C   = ACCUM_W'(HBLANK_CYCLES);
  localparam logic [ACCUM_W-1:0] LINE_C     = ACCUM_W'(LINE_CYCLES);
  localparam logic [LINE_W-1:0]  VIS_LINES  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0]  ALL_LINES  = LINE_W'(VISIBLE_LINES + BLANK_LINES);

  mode_t                 mode, mode_next;
  logic [LINE_W-1:0]     line_count, line_next;
  logic [ACCUM_W-1:0]    cycle_accum, accum_next;
  logic                  line_hit, match_next;
  logic [STAT_EN_W-1:0]  stat_int_enable;
  logic [LINE_W-1:0]     compare_line;

  logic [ACCUM_W:0]      acc_sum;
  logic [ACCUM_W-1:0]    acc_sat;
  logic [LINE_W-1:0]     line_inc;
  logic                  match_inc;
  logic                  match_zero;
  logic                  stat_req;
  logic                  vbl, sdone, tdone, fdone;

  // Accumulate with saturation at the top of the 11-bit range
  assign acc_sum  = {1'b0, cycle_accum} + (ACCUM_W+1)'(cycles);
  assign acc_sat  = acc_sum[ACCUM_W] ? '1 : acc_sum[ACCUM_W-1:0];
  assign line_inc = line_count + LINE_W'(1);
  assign match_inc  = (line_inc == compare_line);
  assign match_zero = (compare_line == '0);

  // Mode state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SEARCH;
    end else if (step_en) begin
      mode <= mode_next;
    end
  end

  // Next mode, line and request logic: at most one transition per word
  always_comb begin
    mode_next  = mode;
    line_next  = line_count;
    match_next = line_hit;
    accum_next = acc_sat;
    stat_req   = 1'b0;
    vbl        = 1'b0;
    sdone      = 1'b0;
    tdone      = 1'b0;
    fdone      = 1'b0;
    unique case (mode)
      MODE_SEARCH: begin
        if (acc_sat >= SEARCH_C) begin
          sdone      = 1'b1;
          mode_next  = MODE_TRANSFER;
          accum_next = acc_sat - SEARCH_C;
        end
      end
      MODE_TRANSFER: begin
        if (acc_sat >= TRANSFER_C) begin
          tdone      = 1'b1;
          stat_req   = stat_int_enable[STAT_EN_HBLANK];
          mode_next  = MODE_HBLANK;
          accum_next = acc_sat - TRANSFER_C;
        end
      end
      MODE_HBLANK: begin
        if (acc_sat >= HBLANK_C) begin
          line_next  = line_inc;
          match_next = match_inc;
          accum_next = acc_sat - HBLANK_C;
          if (line_inc < VIS_LINES) begin
            mode_next = MODE_SEARCH;
            stat_req  = (match_inc & stat_int_enable[STAT_EN_MATCH]) |
                        stat_int_enable[STAT_EN_SEARCH];
          end else begin
            mode_next = MODE_VBLANK;
            vbl       = 1'b1;
            stat_req  = (match_inc & stat_int_enable[STAT_EN_MATCH]) |
                        stat_int_enable[STAT_EN_VBLANK];
          end
        end
      end
      MODE_VBLANK: begin
        if (acc_sat >= LINE_C) begin
          line_next  = line_inc;
          match_next = match_inc;
          accum_next = acc_sat - LINE_C;
          stat_req   = match_inc & stat_int_enable[STAT_EN_MATCH];
          // last blank line: wrap to the top and test line zero too
          if (line_inc == ALL_LINES) begin
            line_next  = '0;
            match_next = match_zero;
            mode_next  = MODE_SEARCH;
            fdone      = 1'b1;
            stat_req   = stat_req |
                         (match_zero & stat_int_enable[STAT_EN_MATCH]) |
                         stat_int_enable[STAT_EN_SEARCH];
          end
        end
      end
    endcase
  end

  // Line, accumulator, match flag and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count      <= '0;
      cycle_accum     <= '0;
      line_hit        <= 1'b1;
      stat_int_enable <= '0;
      compare_line    <= '0;
    end else begin
      if (step_en) begin
        line_count  <= line_next;
        cycle_accum <= accum_next;
      end
      if (cfg.we && cfg.index == REG_STAT_INT_ENABLE) begin
        stat_int_enable <= cfg.data[STAT_EN_W-1:0];
      end
      // a compare write refreshes the flag from the current line
      if (cfg.we && cfg.index == REG_COMPARE_LINE) begin
        compare_line <= cfg.data[LINE_W-1:0];
        line_hit     <= (line_count == cfg.data[LINE_W-1:0]);
      end else if (step_en) begin
        line_hit <= match_next;
      end
    end
  end

  // Result of the current word, registered by the caller
  always_comb begin
    result.mode          = mode_next;
    result.line          = line_next;
    result.line_match    = match_next;
    result.stat_irq      = stat_req;
    result.vblank_irq    = vbl;
    result.search_done   = sdone;
    result.transfer_done = tdone;
    result.frame_done    = fdone;
  end

`ifndef SYNTHESIS
  // End of frame leaves line zero in sprite search
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (step_en && fdone) |=> (line_count == '0 && mode == MODE_SEARCH))
    else $error("frame end did not wrap to line zero in search");

  // Only one phase end per word
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    step_en |-> $onehot0({vbl, sdone, tdone, fdone}))
    else $error("more than one mode transition in a word");

  // Visible modes only on visible lines
  a_line_mode: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_VBLANK) |-> (line_count < VIS_LINES))
    else $error("visible mode outside visible lines");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    (line_count < ALL_LINES))
    else $error("line counter beyond frame");

  // Accumulator moves only with an accepted word
  a_accum_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(cycle_accum))
    else $error("accumulator changed without a word");
`endif

endmodule

### sv/lcd_mode_line_timing.sv
`timescale 1ns / 1ps
// Top level of the LCD mode and line timing block: stream ports, input and
// result registers around lcdt_timing. Depends on lcdt_pkg and lcdt_timing.
module lcd_mode_line_timing #(
  parameter int SEARCH_CYCLES   = 80,
  parameter int TRANSFER_CYCLES = 172,
  parameter int HBLANK_CYCLES   = 204,
  parameter int LINE_CYCLES     = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int BLANK_LINES     = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  // tick words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lcdt_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [5:0] cycles, [7:6] zero
  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lcdt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [1:0] mode, [9:2] line,
                                                            // [10] line_match, [11] stat_irq,
                                                            // [12] vblank_irq, [13] search_done,
                                                            // [14] transfer_done, [15] frame_done
  // configuration writes
  input  logic                              cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  // One tick word per clock is accepted while the result side is not stalled,
  // and one result word is produced for each. A word goes into the input
  // register, then one pass of add, saturate, compare and mode update writes
  // the result register, which drives the output. The sustained rate is one
  // word per cycle when the output is not stalled; backpressure on the result
  // side stalls the input register. Index 0 writes stat_int_enable, index 1
  // compare_line (which also refreshes the match flag); write only while no
  // word is in flight.
  import lcdt_pkg::*;

  logic                 in_valid;
  logic [CYCLES_W-1:0]  in_cycles;
  logic                 advance;
  cfg_wr_t              cfg;
  result_t              step_result;
  result_t              out_result;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cycles <= s_axis_tdata[CYCLES_W-1:0];
    end
  end

  // Timing core
  lcdt_timing #(
    .SEARCH_CYCLES   (SEARCH_CYCLES),
    .TRANSFER_CYCLES (TRANSFER_CYCLES),
    .HBLANK_CYCLES   (HBLANK_CYCLES),
    .LINE_CYCLES     (LINE_CYCLES),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .BLANK_LINES     (BLANK_LINES)
  ) u_timing (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .cycles  (in_cycles),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tdata = out_result;

endmodule
